// ===== rtl/tri2d_pkg.sv =====
// Shared types, register indexes and width helpers for the 2D trilateration core.
// No dependencies.
package tri2d_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int RANGE_BITS     = 16;
  localparam int NUM_REGS       = 6;
  localparam int REG_IDX_BITS   = 3;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_A0X = 3'd0,
    REG_A0Y = 3'd1,
    REG_A1X = 3'd2,
    REG_A1Y = 3'd3,
    REG_A2X = 3'd4,
    REG_A2Y = 3'd5
  } tri2d_reg_e;

  localparam int REG_RST [NUM_REGS] = '{0, 0, 3990, 5440, 3710, -300};

  typedef struct packed {
    logic vld;
    logic neg;
    logic zero;
  } tri2d_ctl_t;

  // width of b terms: d0^2 - di^2 + ki - k0
  function automatic int b_width(int c);
    int m;
    m = (2 * c + 1 > 2 * RANGE_BITS) ? 2 * c + 1 : 2 * RANGE_BITS;
    return m + 2;
  endfunction

  // numerator width: a*b - a*b
  function automatic int num_width(int c);
    return c + b_width(c) + 2;
  endfunction

  // 2*det width
  function automatic int den_width(int c);
    return 2 * c + 3;
  endfunction

endpackage

// ===== rtl/tri2d_front.sv =====
// Front pipeline: squares, linear system terms, determinant and numerators.
// Produces unsigned magnitudes and signs for the dividers. Uses tri2d_pkg.
module tri2d_front #(
  parameter int COORD_BITS = tri2d_pkg::COORD_BITS_DEF,
  parameter int NW         = tri2d_pkg::num_width(COORD_BITS),
  parameter int DW         = tri2d_pkg::den_width(COORD_BITS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                vld_i,
  input  logic [tri2d_pkg::RANGE_BITS-1:0]    range0_i,
  input  logic [tri2d_pkg::RANGE_BITS-1:0]    range1_i,
  input  logic [tri2d_pkg::RANGE_BITS-1:0]    range2_i,
  input  logic signed [COORD_BITS-1:0]        ax0_i,
  input  logic signed [COORD_BITS-1:0]        ay0_i,
  input  logic signed [COORD_BITS-1:0]        ax1_i,
  input  logic signed [COORD_BITS-1:0]        ay1_i,
  input  logic signed [COORD_BITS-1:0]        ax2_i,
  input  logic signed [COORD_BITS-1:0]        ay2_i,
  output logic [NW-1:0]                       num_x_o,
  output logic [NW-1:0]                       num_y_o,
  output logic [DW-1:0]                       den_o,
  output tri2d_pkg::tri2d_ctl_t               ctl_x_o,
  output tri2d_pkg::tri2d_ctl_t               ctl_y_o
);
  import tri2d_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int AW  = C + 1;
  localparam int KW  = 2 * C + 1;
  localparam int SQW = 2 * RANGE_BITS;
  localparam int BW  = b_width(C);
  localparam int PW  = 2 * C + 2;
  localparam int MW  = AW + BW;

  // stage 1
  logic                 s1_vld_q;
  logic [SQW-1:0]       s1_dsq0_q, s1_dsq1_q, s1_dsq2_q;
  logic signed [AW-1:0] s1_a00_q, s1_a01_q, s1_a10_q, s1_a11_q;
  logic signed [KW-1:0] s1_k0_q, s1_k1_q, s1_k2_q;
  logic signed [2*C-1:0] sqx0, sqy0, sqx1, sqy1, sqx2, sqy2;

  assign sqx0 = ax0_i * ax0_i;
  assign sqy0 = ay0_i * ay0_i;
  assign sqx1 = ax1_i * ax1_i;
  assign sqy1 = ay1_i * ay1_i;
  assign sqx2 = ax2_i * ax2_i;
  assign sqy2 = ay2_i * ay2_i;

  always_ff @(posedge clk_i) begin
    s1_dsq0_q <= SQW'(range0_i) * SQW'(range0_i);
    s1_dsq1_q <= SQW'(range1_i) * SQW'(range1_i);
    s1_dsq2_q <= SQW'(range2_i) * SQW'(range2_i);
    s1_a00_q  <= AW'(ax1_i) - AW'(ax0_i);
    s1_a01_q  <= AW'(ay1_i) - AW'(ay0_i);
    s1_a10_q  <= AW'(ax2_i) - AW'(ax0_i);
    s1_a11_q  <= AW'(ay2_i) - AW'(ay0_i);
    s1_k0_q   <= KW'(sqx0) + KW'(sqy0);
    s1_k1_q   <= KW'(sqx1) + KW'(sqy1);
    s1_k2_q   <= KW'(sqx2) + KW'(sqy2);
  end

  // stage 2
  logic                 s2_vld_q;
  logic signed [BW-1:0] s2_b0_q, s2_b1_q;
  logic signed [PW-1:0] s2_pd0_q, s2_pd1_q;
  logic signed [AW-1:0] s2_a00_q, s2_a01_q, s2_a10_q, s2_a11_q;
  logic signed [BW-1:0] dsq0_s, dsq1_s, dsq2_s;

  assign dsq0_s = BW'($signed({1'b0, s1_dsq0_q}));
  assign dsq1_s = BW'($signed({1'b0, s1_dsq1_q}));
  assign dsq2_s = BW'($signed({1'b0, s1_dsq2_q}));

  always_ff @(posedge clk_i) begin
    s2_b0_q  <= dsq0_s - dsq1_s + BW'(s1_k1_q) - BW'(s1_k0_q);
    s2_b1_q  <= dsq0_s - dsq2_s + BW'(s1_k2_q) - BW'(s1_k0_q);
    s2_pd0_q <= PW'(s1_a00_q) * PW'(s1_a11_q);
    s2_pd1_q <= PW'(s1_a10_q) * PW'(s1_a01_q);
    s2_a00_q <= s1_a00_q;
    s2_a01_q <= s1_a01_q;
    s2_a10_q <= s1_a10_q;
    s2_a11_q <= s1_a11_q;
  end

  // stage 3
  logic                 s3_vld_q;
  logic signed [PW-1:0] s3_det_q;
  logic signed [MW-1:0] s3_m0_q, s3_m1_q, s3_m2_q, s3_m3_q;

  always_ff @(posedge clk_i) begin
    s3_det_q <= s2_pd0_q - s2_pd1_q;
    s3_m0_q  <= MW'(s2_a11_q) * MW'(s2_b0_q);
    s3_m1_q  <= MW'(s2_a01_q) * MW'(s2_b1_q);
    s3_m2_q  <= MW'(s2_a00_q) * MW'(s2_b1_q);
    s3_m3_q  <= MW'(s2_a10_q) * MW'(s2_b0_q);
  end

  // stage 4
  logic                 s4_vld_q;
  logic signed [NW-1:0] s4_nx_q, s4_ny_q;
  logic signed [DW-1:0] s4_den_q;
  logic                 s4_zero_q;

  always_ff @(posedge clk_i) begin
    s4_nx_q   <= NW'(s3_m0_q) - NW'(s3_m1_q);
    s4_ny_q   <= NW'(s3_m2_q) - NW'(s3_m3_q);
    s4_den_q  <= {s3_det_q, 1'b0};
    s4_zero_q <= (s3_det_q == '0);
  end

  // stage 5: magnitudes and signs
  logic [NW-1:0] num_x_q, num_y_q;
  logic [DW-1:0] den_q;
  tri2d_ctl_t    ctl_x_d, ctl_y_d, ctl_x_q, ctl_y_q;

  always_ff @(posedge clk_i) begin
    num_x_q <= s4_nx_q[NW-1] ? NW'(-s4_nx_q) : NW'(s4_nx_q);
    num_y_q <= s4_ny_q[NW-1] ? NW'(-s4_ny_q) : NW'(s4_ny_q);
    den_q   <= s4_den_q[DW-1] ? DW'(-s4_den_q) : DW'(s4_den_q);
  end

  always_comb begin
    ctl_x_d.vld  = s4_vld_q;
    ctl_x_d.neg  = s4_nx_q[NW-1] ^ s4_den_q[DW-1];
    ctl_x_d.zero = s4_zero_q;
    ctl_y_d.vld  = s4_vld_q;
    ctl_y_d.neg  = s4_ny_q[NW-1] ^ s4_den_q[DW-1];
    ctl_y_d.zero = s4_zero_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      ctl_x_q  <= '0;
      ctl_y_q  <= '0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      ctl_x_q  <= ctl_x_d;
      ctl_y_q  <= ctl_y_d;
    end
  end

  assign num_x_o = num_x_q;
  assign num_y_o = num_y_q;
  assign den_o   = den_q;
  assign ctl_x_o = ctl_x_q;
  assign ctl_y_o = ctl_y_q;

endmodule

// ===== rtl/tri2d_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with saturation
// to a signed COORD_BITS result and forced zero for a singular system. Uses tri2d_pkg.
module tri2d_div #(
  parameter int COORD_BITS = tri2d_pkg::COORD_BITS_DEF,
  parameter int NW         = tri2d_pkg::num_width(COORD_BITS),
  parameter int DW         = tri2d_pkg::den_width(COORD_BITS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [NW-1:0]                num_i,
  input  logic [DW-1:0]                den_i,
  input  tri2d_pkg::tri2d_ctl_t        ctl_i,
  output logic signed [COORD_BITS-1:0] q_o,
  output tri2d_pkg::tri2d_ctl_t        ctl_o
);
  import tri2d_pkg::*;

  localparam int C = COORD_BITS;

  logic [NW-1:0] r_q   [C+1];
  logic [DW-1:0] d_q   [C+1];
  logic [C-1:0]  q_q   [C+1];
  logic          ovf_q [C+1];
  tri2d_ctl_t    ctl_q [C+1];

  // quotient of more than C bits flags overflow and saturates
  always_ff @(posedge clk_i) begin
    r_q[0]   <= num_i;
    d_q[0]   <= den_i;
    q_q[0]   <= '0;
    ovf_q[0] <= (num_i >= (NW'(den_i) << C));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
    end
  end

  for (genvar j = 0; j < C; j++) begin : g_step
    logic [NW-1:0] sh;
    logic          take;

    assign sh   = NW'(d_q[j]) << (C - 1 - j);
    assign take = (r_q[j] >= sh);

    always_ff @(posedge clk_i) begin
      r_q[j+1]   <= take ? r_q[j] - sh : r_q[j];
      d_q[j+1]   <= d_q[j];
      q_q[j+1]   <= q_q[j] | (C'(take) << (C - 1 - j));
      ovf_q[j+1] <= ovf_q[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[j+1] <= '0;
      end else begin
        ctl_q[j+1] <= ctl_q[j];
      end
    end
  end

  localparam logic [C-1:0] HALF = {1'b1, {(C-1){1'b0}}};

  logic [C-1:0] lim, qs;
  logic [C-1:0] q_d;
  logic [C-1:0] q_out_q;
  tri2d_ctl_t   ctl_out_q;

  always_comb begin
    lim = ctl_q[C].neg ? HALF : HALF - C'(1);
    qs  = (ovf_q[C] || (q_q[C] > lim)) ? lim : q_q[C];
    if (ctl_q[C].zero) begin
      q_d = '0;
    end else if (ctl_q[C].neg) begin
      q_d = C'(-qs);
    end else begin
      q_d = qs;
    end
  end

  always_ff @(posedge clk_i) begin
    q_out_q <= q_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_out_q <= '0;
    end else begin
      ctl_out_q <= ctl_q[C];
    end
  end

  assign q_o   = $signed(q_out_q);
  assign ctl_o = ctl_out_q;

endmodule

// ===== rtl/trilateration_2d_three_anchor_core.sv =====
// 2D trilateration core: anchor registers, front pipeline and two dividers.
// The path from start to done runs through five arithmetic stages and a divider
// of one stage per quotient bit plus two.
// Throughput: one range triple per cycle; busy stays low, results never stall.
// Reset clears all valid bits and loads the anchor registers with their defaults.
module trilateration_2d_three_anchor_core #(
  parameter int COORD_BITS = tri2d_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [tri2d_pkg::RANGE_BITS-1:0]     range0_i,
  input  logic [tri2d_pkg::RANGE_BITS-1:0]     range1_i,
  input  logic [tri2d_pkg::RANGE_BITS-1:0]     range2_i,
  input  logic                                 cfg_we_i,
  input  logic [tri2d_pkg::REG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [COORD_BITS-1:0]                cfg_wdata_i,
  output logic                                 done_o,
  output logic signed [COORD_BITS-1:0]         pos_x_o,
  output logic signed [COORD_BITS-1:0]         pos_y_o,
  output logic                                 singular_o
);
  import tri2d_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int NW = num_width(C);
  localparam int DW = den_width(C);

  logic [C-1:0] regs_q [NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= C'(REG_RST[i]);
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_A0X: regs_q[0] <= cfg_wdata_i;
        REG_A0Y: regs_q[1] <= cfg_wdata_i;
        REG_A1X: regs_q[2] <= cfg_wdata_i;
        REG_A1Y: regs_q[3] <= cfg_wdata_i;
        REG_A2X: regs_q[4] <= cfg_wdata_i;
        REG_A2Y: regs_q[5] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [NW-1:0] num_x, num_y;
  logic [DW-1:0] den;
  tri2d_ctl_t    ctl_x, ctl_y, out_cx, out_cy;

  tri2d_front #(
    .COORD_BITS(C),
    .NW        (NW),
    .DW        (DW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (start && !busy),
    .range0_i(range0_i),
    .range1_i(range1_i),
    .range2_i(range2_i),
    .ax0_i   ($signed(regs_q[0])),
    .ay0_i   ($signed(regs_q[1])),
    .ax1_i   ($signed(regs_q[2])),
    .ay1_i   ($signed(regs_q[3])),
    .ax2_i   ($signed(regs_q[4])),
    .ay2_i   ($signed(regs_q[5])),
    .num_x_o (num_x),
    .num_y_o (num_y),
    .den_o   (den),
    .ctl_x_o (ctl_x),
    .ctl_y_o (ctl_y)
  );

  tri2d_div #(
    .COORD_BITS(C),
    .NW        (NW),
    .DW        (DW)
  ) u_div_x (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .num_i (num_x),
    .den_i (den),
    .ctl_i (ctl_x),
    .q_o   (pos_x_o),
    .ctl_o (out_cx)
  );

  tri2d_div #(
    .COORD_BITS(C),
    .NW        (NW),
    .DW        (DW)
  ) u_div_y (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .num_i (num_y),
    .den_i (den),
    .ctl_i (ctl_y),
    .q_o   (pos_y_o),
    .ctl_o (out_cy)
  );

  assign done_o     = out_cx.vld & out_cy.vld;
  assign singular_o = out_cx.zero | out_cy.zero;

endmodule

// ===== tb/tri2d_checker.sv =====
// Checker for the 2D trilateration core: tracks anchor writes, predicts each position
// from accepted range transfers and compares results field by field. Depends on tri2d_pkg.
`timescale 1ns / 100ps
module tri2d_checker #(
  parameter int COORD_BITS = tri2d_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic                                busy,
  input  logic [tri2d_pkg::RANGE_BITS-1:0]    range0_i,
  input  logic [tri2d_pkg::RANGE_BITS-1:0]    range1_i,
  input  logic [tri2d_pkg::RANGE_BITS-1:0]    range2_i,
  input  logic                                cfg_we_i,
  input  logic [tri2d_pkg::REG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [COORD_BITS-1:0]               cfg_wdata_i,
  input  logic                                done_o,
  input  logic signed [COORD_BITS-1:0]        pos_x_o,
  input  logic signed [COORD_BITS-1:0]        pos_y_o,
  input  logic                                singular_o,
  output int                                  fail_cnt,
  output int                                  pending
);
  import tri2d_pkg::*;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         sing;
  } position_t;

  logic signed [COORD_BITS-1:0] anchor [NUM_REGS];
  position_t                    expected_pos [$];

  function automatic logic signed [COORD_BITS-1:0] sat_div(longint num, longint den);
    longint q;
    longint hi;
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    q  = num / den;
    if (q > hi) q = hi;
    if (q < -hi - 1) q = -hi - 1;
    return q[COORD_BITS-1:0];
  endfunction

  function automatic position_t solve_position(logic [RANGE_BITS-1:0] r0,
                                               logic [RANGE_BITS-1:0] r1,
                                               logic [RANGE_BITS-1:0] r2);
    longint x0, y0, x1, y1, x2, y2, d0, d1, d2;
    longint a00, a01, a10, a11, b0, b1, det;
    position_t p;
    x0 = anchor[REG_A0X]; y0 = anchor[REG_A0Y];
    x1 = anchor[REG_A1X]; y1 = anchor[REG_A1Y];
    x2 = anchor[REG_A2X]; y2 = anchor[REG_A2Y];
    d0 = r0; d1 = r1; d2 = r2;
    a00 = x1 - x0; a01 = y1 - y0;
    a10 = x2 - x0; a11 = y2 - y0;
    b0  = d0*d0 - d1*d1 + (x1*x1 + y1*y1) - (x0*x0 + y0*y0);
    b1  = d0*d0 - d2*d2 + (x2*x2 + y2*y2) - (x0*x0 + y0*y0);
    det = a00*a11 - a10*a01;
    p = '0;
    if (det == 0) begin
      p.sing = 1'b1;
    end else begin
      p.x = sat_div(a11*b0 - a01*b1, 2*det);
      p.y = sat_div(a00*b1 - a10*b0, 2*det);
    end
    return p;
  endfunction

  assign pending = expected_pos.size();

  always @(posedge clk_i or negedge rst_ni) begin
    position_t e;
    int        errs;
    errs = 0;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) anchor[i] <= COORD_BITS'(REG_RST[i]);
      expected_pos.delete();
      fail_cnt <= 0;
    end else begin
      if (done_o) begin
        if (expected_pos.size() == 0) begin
          $error("unexpected result transfer");
          errs++;
        end else begin
          e = expected_pos.pop_front();
          if (pos_x_o !== e.x) begin
            $error("pos_x expected %0d actual %0d", e.x, pos_x_o);
            errs++;
          end
          if (pos_y_o !== e.y) begin
            $error("pos_y expected %0d actual %0d", e.y, pos_y_o);
            errs++;
          end
          if (singular_o !== e.sing) begin
            $error("singular expected %0d actual %0d", e.sing, singular_o);
            errs++;
          end
        end
      end
      fail_cnt <= fail_cnt + errs;
      if (start && !busy)
        expected_pos.push_back(solve_position(range0_i, range1_i, range2_i));
      if (cfg_we_i && cfg_idx_i < NUM_REGS)
        anchor[cfg_idx_i] <= cfg_wdata_i;
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the 2D trilateration core: drives range triples and anchor writes,
// checking is done in tri2d_checker. Depends on tri2d_pkg and the core.
`timescale 1ns / 100ps
module tb;
  import tri2d_pkg::*;

  localparam int CB        = COORD_BITS_DEF;
  localparam int LATENCY   = CB + 7;
  localparam int WDOG_MAX  = 5000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  busy_n = 1'b0;
  logic [RANGE_BITS-1:0] range0_i = '0, range1_i = '0, range2_i = '0;
  logic                  cfg_we_i = 1'b0;
  tri2d_reg_e            cfg_idx_i = REG_A0X;
  logic [CB-1:0]         cfg_wdata_i = '0;
  logic                  done_o, singular_o;
  logic signed [CB-1:0]  pos_x_o, pos_y_o;
  int                    fail_cnt, pending;
  int                    sender_idle_pct = 0;
  int                    stall_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  trilateration_2d_three_anchor_core #(.COORD_BITS(CB)) dut (
    .clk_i, .rst_ni, .start, .busy, .range0_i, .range1_i, .range2_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done_o, .pos_x_o, .pos_y_o, .singular_o
  );

  tri2d_checker #(.COORD_BITS(CB)) u_checker (
    .clk_i, .rst_ni, .start, .busy, .range0_i, .range1_i, .range2_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .done_o, .pos_x_o, .pos_y_o, .singular_o,
    .fail_cnt, .pending
  );

  // busy only moves at rising edges, so the value seen at the falling edge holds at the next
  always @(negedge clk_i) busy_n <= busy;

  always @(posedge clk_i) begin
    if ((start && !busy_n) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WDOG_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_ranges(int r0, int r1, int r2);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
    start    <= 1'b1;
    range0_i <= RANGE_BITS'(r0);
    range1_i <= RANGE_BITS'(r1);
    range2_i <= RANGE_BITS'(r2);
    forever begin
      @(posedge clk_i);
      if (!busy_n) break;
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_anchor(tri2d_reg_e idx, int val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CB'(val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic load_anchors(int ax0, int ay0, int ax1, int ay1, int ax2, int ay2);
    drain();
    write_anchor(REG_A0X, ax0);
    write_anchor(REG_A0Y, ay0);
    write_anchor(REG_A1X, ax1);
    write_anchor(REG_A1Y, ay1);
    write_anchor(REG_A2X, ax2);
    write_anchor(REG_A2Y, ay2);
  endtask

  // ranges from a point near the anchors, with a little noise
  task automatic send_consistent(int ax [6]);
    int  px, py, r [3];
    real dx, dy;
    px = int'($urandom_range(20000)) - 10000;
    py = int'($urandom_range(20000)) - 10000;
    for (int i = 0; i < 3; i++) begin
      dx = real'(px - ax[2*i]);
      dy = real'(py - ax[2*i+1]);
      r[i] = int'($sqrt(dx*dx + dy*dy)) + int'($urandom_range(40)) - 20;
      if (r[i] < 0) r[i] = 0;
      if (r[i] > 65535) r[i] = 65535;
    end
    send_ranges(r[0], r[1], r[2]);
  endtask

  task automatic random_batch(int n, int ax [6]);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0, 1: send_consistent(ax);
        2: send_ranges($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
        default: send_ranges($urandom_range(15000), $urandom_range(15000),
                             $urandom_range(15000));
      endcase
      if (i == n / 2 && $urandom_range(1)) drain();
    end
  endtask

  initial begin
    int ax [6];
    int pct [3];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset anchors
    send_ranges(0, 0, 0);
    send_ranges(65535, 65535, 65535);
    send_ranges(65535, 0, 0);
    send_ranges(0, 65535, 0);
    send_ranges(0, 0, 65535);
    send_ranges(0, 65535, 65535);
    send_ranges(43690, 21845, 65535);
    send_ranges(3000, 3000, 3000);
    send_ranges(2500, 4200, 2100);
    send_ranges(1, 2, 4);
    // collinear anchors
    load_anchors(0, 0, 1000, 1000, -2000, -2000);
    send_ranges(100, 200, 300);
    send_ranges(65535, 0, 65535);
    // coincident anchors
    load_anchors(32767, 32767, 32767, 32767, 32767, 32767);
    send_ranges(5, 6, 7);
    // extreme corners
    load_anchors(-32768, -32768, 32767, -32768, -32768, 32767);
    send_ranges(0, 65535, 65535);
    send_ranges(65535, 0, 0);
    send_ranges(46340, 46340, 46340);
    // nearly collinear, quotient saturates
    load_anchors(0, 0, 32767, 1, -32768, 0);
    send_ranges(65535, 0, 40000);
    send_ranges(0, 65535, 12345);
    send_ranges(30000, 20000, 65535);

    pct = '{38, 86, 0};
    for (int ph = 0; ph < 6; ph++) begin
      sender_idle_pct = pct[ph % 3];
      case (ph)
        0: ax = '{0, 0, 3990, 5440, 3710, -300};
        1: ax = '{-5000, -5000, 5000, -5000, 0, 6000};
        2: ax = '{32767, -32768, -32768, 32767, 0, 0};
        default: begin
          for (int i = 0; i < 6; i++) ax[i] = int'($urandom_range(16000)) - 8000;
        end
      endcase
      load_anchors(ax[0], ax[1], ax[2], ax[3], ax[4], ax[5]);
      random_batch(95, ax);
    end

    drain();
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tri2d_pkg.sv
rtl/tri2d_front.sv
rtl/tri2d_div.sv
rtl/trilateration_2d_three_anchor_core.sv
tb/tri2d_checker.sv
tb/tb.sv
